/* hw/rtl/pfra_pkg.sv */
// ============================================================================
// Page frame run allocator: shared definitions
// Field widths, request kinds, result codes and register indexes used by the
// allocator.
// ============================================================================
package pfra_pkg;

   // Fixed field widths of the request and result beats.
   localparam int ADDR_W   = 48;
   localparam int KIND_W   = 2;
   localparam int COUNT_W  = 16;
   localparam int STATUS_W = 3;
   localparam int TOTAL_W  = 36;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;

   typedef logic [KIND_W-1:0]    kind_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [ADDR_W-1:0]    addr_type;
   typedef logic [TOTAL_W-1:0]   total_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // Request kinds.
   localparam kind_type KIND_ALLOC = 2'd0;
   localparam kind_type KIND_FREE  = 2'd1;
   localparam kind_type KIND_RANGE = 2'd2;

   // Result codes.
   localparam status_type STATUS_OK         = 3'd0;
   localparam status_type STATUS_NO_MEMORY  = 3'd1;
   localparam status_type STATUS_MULTI_PAGE = 3'd2;
   localparam status_type STATUS_MISALIGNED = 3'd3;
   localparam status_type STATUS_BELOW_KERN = 3'd4;
   localparam status_type STATUS_EMPTY_RNG  = 3'd5;
   localparam status_type STATUS_TABLE_FULL = 3'd6;

   // Register indexes.
   localparam csr_idx_type CSR_VM_ENABLED = 1'd0;
   localparam csr_idx_type CSR_KERNEL_END = 1'd1;

   // Saturation limit of the free page count.
   localparam total_type TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

/* hw/rtl/page_frame_run_allocator.sv */
// ============================================================================
// Page frame run allocator
// Keeps free physical memory as a linked list of runs (start page, length)
// in on-chip memories and serves allocate, free and add range requests.
// ============================================================================
// Each request beat is taken in the idle state and then walks a short
// sequencer around two memories (run start and length in one, run links
// in the other), each with a registered read port and a write port. A
// rejected request goes from CHECK to DONE, an allocate through ALLOC, a
// free through WRITE (after TAKE when a spare entry is reused) and an add
// range through WRITE (after TAKE for a spare entry), then LINK and RELINK
// to splice behind an existing head. The order is set by the read, modify
// and write-back of the link memory, which is written at most once a cycle.
// A finished result waits in the output register; the next request beat is
// taken while it waits. The memories need no clearing pass after reset.
module page_frame_run_allocator #(
   parameter int RUN_ENTRIES = 1024,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration port
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  pfra_pkg::csr_idx_type       csr_index,
   input  logic [pfra_pkg::CSR_DATA_W-1:0] csr_wdata,
   // Request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pfra_pkg::kind_type          req_kind,
   input  logic [pfra_pkg::COUNT_W-1:0] req_page_count,
   input  pfra_pkg::addr_type          req_address,
   input  pfra_pkg::addr_type          req_range_start,
   input  pfra_pkg::addr_type          req_range_end,
   // Result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pfra_pkg::status_type        rsp_status,
   output pfra_pkg::addr_type          rsp_page_address,
   output pfra_pkg::total_type         rsp_free_pages
);
   import pfra_pkg::*;

   localparam int IDX_W  = (RUN_ENTRIES > 1) ? $clog2(RUN_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(RUN_ENTRIES + 1);
   localparam int PN_W   = ADDR_W - PAGE_SHIFT;
   localparam int RUN_W  = 2 * PN_W;
   localparam int SUM_W  = ((PN_W > TOTAL_W) ? PN_W : TOTAL_W) + 1;
   localparam logic [ADDR_W:0]  PAGE_ROUND = (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);
   localparam logic [CNT_W-1:0] ENTRIES_C  = CNT_W'(RUN_ENTRIES);
   localparam logic [PN_W-1:0]  PN_MAX     = {PN_W{1'b1}};
   localparam logic [PN_W-1:0]  PN_ONE     = PN_W'(1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_ALLOC  = 3'd2;
   localparam logic [2:0] S_TAKE   = 3'd3;
   localparam logic [2:0] S_WRITE  = 3'd4;
   localparam logic [2:0] S_LINK   = 3'd5;
   localparam logic [2:0] S_RELINK = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic             vm_enabled_ff;
   addr_type         kernel_end_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic             list_ne_ff, list_ne_in;
   logic [IDX_W-1:0] spare_ff, spare_in;
   logic             spare_ne_ff, spare_ne_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   total_type        total_ff, total_in;
   logic             rsp_valid_ff;

   // Request and working registers.
   kind_type           kind_ff;
   logic [COUNT_W-1:0] count_ff;
   addr_type           addr_ff;
   logic [PN_W:0]      sp_ff, ep_ff;
   logic [IDX_W-1:0]   entry_ff, entry_in;
   logic [IDX_W-1:0]   next_link_ff, next_link_in;
   status_type         status_ff, status_in;
   addr_type           page_ff, page_in;
   status_type         rsp_status_ff;
   addr_type           rsp_page_ff;
   total_type          rsp_free_ff;

   // Memories and their ports.
   logic [RUN_W-1:0] run_mem  [RUN_ENTRIES];
   logic [IDX_W-1:0] link_mem [RUN_ENTRIES];
   logic [RUN_W-1:0] run_rd_ff;
   logic [IDX_W-1:0] link_rd_ff;
   logic [IDX_W-1:0] run_raddr, link_raddr, run_waddr, link_waddr;
   logic             run_we, link_we;
   logic [RUN_W-1:0] run_wdata;
   logic [IDX_W-1:0] link_wdata;

   // Helper values.
   logic [ADDR_W:0]  rs_sum, re_sum;
   logic [PN_W:0]    len_full;
   logic [PN_W-1:0]  range_len;
   logic [SUM_W-1:0] total_sum;
   logic [CNT_W-1:0] fresh_pos;
   logic [IDX_W-1:0] fresh_idx;
   logic             entry_avail;
   logic [PN_W-1:0]  rd_start, rd_len;
   logic             req_fire, rsp_free_slot;

   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_page_address = rsp_page_ff;
   assign rsp_free_pages   = rsp_free_ff;
   assign rsp_free_slot    = !rsp_valid_ff || rsp_ready;

   // Both range ends are rounded up to a page as the beat is taken.
   assign rs_sum = {1'b0, req_range_start} + PAGE_ROUND;
   assign re_sum = {1'b0, req_range_end} + PAGE_ROUND;

   // Run length of an add range, clipped to the page number width.
   assign len_full  = ep_ff - sp_ff;
   assign range_len = len_full[PN_W] ? PN_MAX : len_full[PN_W-1:0];

   // The next fresh entry sits just above those already handed out.
   assign fresh_pos   = ENTRIES_C - fresh_ff;
   assign fresh_idx   = fresh_pos[IDX_W-1:0];
   assign entry_avail = spare_ne_ff || (fresh_ff != '0);

   assign rd_start = run_rd_ff[RUN_W-1:PN_W];
   assign rd_len   = run_rd_ff[PN_W-1:0];

   // Sequencer: reads in one state, modifies and writes back in the next.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      list_ne_in   = list_ne_ff;
      spare_in     = spare_ff;
      spare_ne_in  = spare_ne_ff;
      fresh_in     = fresh_ff;
      total_in     = total_ff;
      entry_in     = entry_ff;
      next_link_in = next_link_ff;
      status_in    = status_ff;
      page_in      = page_ff;
      run_raddr    = head_ff;
      link_raddr   = head_ff;
      run_we       = 1'b0;
      run_waddr    = entry_ff;
      run_wdata    = {sp_ff[PN_W-1:0], range_len};
      link_we      = 1'b0;
      link_waddr   = entry_ff;
      link_wdata   = entry_ff;
      total_sum    = {{(SUM_W-TOTAL_W){1'b0}}, total_ff} + SUM_W'(range_len);

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            status_in = STATUS_OK;
            page_in   = '0;
            state_in  = S_DONE;
            case (kind_ff)
               KIND_ALLOC: begin
                  if (count_ff > COUNT_W'(1) && !vm_enabled_ff) begin
                     status_in = STATUS_MULTI_PAGE;
                  end else if (!list_ne_ff) begin
                     status_in = STATUS_NO_MEMORY;
                  end else begin
                     // Head run and its link are read here.
                     state_in = S_ALLOC;
                  end
               end
               KIND_FREE, KIND_RANGE: begin
                  if (kind_ff == KIND_FREE && addr_ff[PAGE_SHIFT-1:0] != '0) begin
                     status_in = STATUS_MISALIGNED;
                  end else if (kind_ff == KIND_FREE && addr_ff < kernel_end_ff) begin
                     status_in = STATUS_BELOW_KERN;
                  end else if (kind_ff == KIND_RANGE && ep_ff <= sp_ff) begin
                     status_in = STATUS_EMPTY_RNG;
                  end else if (!entry_avail) begin
                     status_in = STATUS_TABLE_FULL;
                  end else if (spare_ne_ff) begin
                     // Reuse the head of the spare list; its link is read here.
                     entry_in   = spare_ff;
                     link_raddr = spare_ff;
                     state_in   = S_TAKE;
                  end else begin
                     entry_in = fresh_idx;
                     fresh_in = fresh_ff - CNT_W'(1);
                     state_in = S_WRITE;
                  end
               end
               default: begin
               end
            endcase
         end

         S_ALLOC: begin
            page_in = {rd_start, {PAGE_SHIFT{1'b0}}};
            if (rd_len > PN_ONE) begin
               // Shrink the head run by its first page.
               run_we    = 1'b1;
               run_waddr = head_ff;
               run_wdata = {rd_start + PN_ONE, rd_len - PN_ONE};
            end else begin
               // Run used up: unlink it and give its entry back.
               if (link_rd_ff == head_ff) begin
                  list_ne_in = 1'b0;
               end else begin
                  head_in = link_rd_ff;
               end
               link_we     = 1'b1;
               link_waddr  = head_ff;
               link_wdata  = spare_ne_ff ? spare_ff : head_ff;
               spare_in    = head_ff;
               spare_ne_in = 1'b1;
            end
            if (total_ff != '0) begin
               total_in = total_ff - TOTAL_W'(1);
            end
            state_in = S_DONE;
         end

         S_TAKE: begin
            if (link_rd_ff == spare_ff) begin
               spare_ne_in = 1'b0;
            end else begin
               spare_in = link_rd_ff;
            end
            state_in = S_WRITE;
         end

         S_WRITE: begin
            run_we = 1'b1;
            if (kind_ff == KIND_FREE) begin
               // One-page run pushed at the head.
               run_wdata  = {addr_ff[ADDR_W-1:PAGE_SHIFT], PN_ONE};
               link_we    = 1'b1;
               link_wdata = list_ne_ff ? head_ff : entry_ff;
               head_in    = entry_ff;
               list_ne_in = 1'b1;
               if (total_ff != TOTAL_MAX) begin
                  total_in = total_ff + TOTAL_W'(1);
               end
               state_in = S_DONE;
            end else if (!list_ne_ff) begin
               link_we    = 1'b1;
               head_in    = entry_ff;
               list_ne_in = 1'b1;
               total_in   = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                            : total_sum[TOTAL_W-1:0];
               state_in   = S_DONE;
            end else begin
               // Read the head link to splice the new run behind the head.
               link_raddr = head_ff;
               state_in   = S_LINK;
            end
         end

         S_LINK: begin
            link_we      = 1'b1;
            link_wdata   = (link_rd_ff == head_ff) ? entry_ff : link_rd_ff;
            next_link_in = entry_ff;
            state_in     = S_RELINK;
         end

         S_RELINK: begin
            link_we    = 1'b1;
            link_waddr = head_ff;
            link_wdata = next_link_ff;
            total_in   = (total_sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                         : total_sum[TOTAL_W-1:0];
            state_in   = S_DONE;
         end

         S_DONE: begin
            if (rsp_free_slot) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         list_ne_ff    <= 1'b0;
         spare_ff      <= '0;
         spare_ne_ff   <= 1'b0;
         fresh_ff      <= ENTRIES_C;
         total_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         vm_enabled_ff <= 1'b0;
         kernel_end_ff <= '0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         list_ne_ff  <= list_ne_in;
         spare_ff    <= spare_in;
         spare_ne_ff <= spare_ne_in;
         fresh_ff    <= fresh_in;
         total_ff    <= total_in;
         if (state_ff == S_DONE && rsp_free_slot) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // Register writes must come only while idle; it is not enforced.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_VM_ENABLED: vm_enabled_ff <= csr_wdata[0];
               CSR_KERNEL_END: kernel_end_ff <= csr_wdata[ADDR_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Request capture, working values and the result beat.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff  <= req_kind;
         count_ff <= req_page_count;
         addr_ff  <= req_address;
         sp_ff    <= rs_sum[ADDR_W:PAGE_SHIFT];
         ep_ff    <= re_sum[ADDR_W:PAGE_SHIFT];
      end
      entry_ff     <= entry_in;
      next_link_ff <= next_link_in;
      status_ff    <= status_in;
      page_ff      <= page_in;
      if (state_ff == S_DONE && rsp_free_slot) begin
         rsp_status_ff <= status_ff;
         rsp_page_ff   <= page_ff;
         rsp_free_ff   <= total_ff;
      end
   end

   // Run table: start page and length.
   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[run_waddr] <= run_wdata;
      end
      run_rd_ff <= run_mem[run_raddr];
   end

   // Link table.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   // The count of unused entries never exceeds the table size.
   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= ENTRIES_C)
      else $error("fresh entry count above table size");

   // An allocation is only carried out on a non-empty list.
   a_alloc_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC |-> list_ne_ff)
      else $error("allocation from an empty run list");

   // A completed free leaves the list non-empty with the new entry at its head.
   a_free_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && kind_ff == KIND_FREE) |=>
         (list_ne_ff && head_ff == $past(entry_ff)))
      else $error("freed page not at the head of the list");

   // A rejected request leaves the free page count untouched.
   a_error_total: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && state_in == S_DONE) |=> $stable(total_ff))
      else $error("free page count changed by a rejected request");

   // A result beat is only loaded while the output register can take it.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && state_ff == S_DONE) |=> state_ff == S_DONE)
      else $error("result dropped while the output was stalled");

endmodule

/* verif/pfra_result_check.sv */
// ============================================================================
// Page frame run allocator: result checker
// Watches the register, request and result channels of the allocator. It
// keeps its own copy of the free run list, works out the reply to every
// request beat and compares each result beat with the oldest reply that is
// still owed. Mismatches are counted and handed to the testbench top.
// ============================================================================
`timescale 1ns / 1ps

module pfra_result_check #(
   parameter int RUN_ENTRIES = 1024,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  pfra_pkg::csr_idx_type            csr_index,
   input  logic [pfra_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  pfra_pkg::kind_type               req_kind,
   input  logic [pfra_pkg::COUNT_W-1:0]     req_page_count,
   input  pfra_pkg::addr_type               req_address,
   input  pfra_pkg::addr_type               req_range_start,
   input  pfra_pkg::addr_type               req_range_end,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  pfra_pkg::status_type             rsp_status,
   input  pfra_pkg::addr_type               rsp_page_address,
   input  pfra_pkg::total_type              rsp_free_pages,
   input  logic                             end_of_test,
   output int                               outstanding,
   output int                               failures
);
   import pfra_pkg::*;

   localparam int PN_W = ADDR_W - PAGE_SHIFT;
   localparam logic [63:0] PAGE_NUMBER_MAX = (64'h1 << PN_W) - 64'h1;
   localparam logic [63:0] PAGE_ROUND      = (64'h1 << PAGE_SHIFT) - 64'h1;

   typedef struct packed {
      status_type status;
      addr_type   page_address;
      total_type  free_pages;
   } reply_type;

   // Replies owed by the block, oldest first.
   reply_type awaited_replies[$];

   // Shadow of the run table and the list heads.
   logic [PN_W-1:0] run_first [RUN_ENTRIES];
   logic [PN_W-1:0] run_pages [RUN_ENTRIES];
   int              run_next  [RUN_ENTRIES];
   int              head;
   int              spare_top;
   int              unused_entries;
   logic            list_live;
   logic            spare_live;
   total_type       page_total;

   // Register copies.
   logic            vm_on;
   addr_type        kernel_end;

   // Run statistics for the closing summary.
   int              status_seen [8];
   int              register_writes;
   int              runs_held;
   int              runs_peak;
   logic            closed;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      failures++;
   endtask

   function automatic logic entry_available();
      return spare_live || unused_entries > 0;
   endfunction

   // A spare entry is reused before a never-used one is handed out.
   function automatic int claim_entry();
      int e;
      if (spare_live) begin
         e = spare_top;
         if (run_next[e] == e)
            spare_live = 1'b0;
         else
            spare_top = run_next[e];
      end else begin
         e = RUN_ENTRIES - unused_entries;
         unused_entries--;
      end
      runs_held++;
      if (runs_held > runs_peak)
         runs_peak = runs_held;
      return e;
   endfunction

   function automatic void retire_entry(input int e);
      run_next[e] = spare_live ? spare_top : e;
      spare_top   = e;
      spare_live  = 1'b1;
      runs_held--;
   endfunction

   // The free page count saturates rather than wrapping.
   function automatic void credit_pages(input logic [63:0] n);
      if (n > 64'(TOTAL_MAX) - 64'(page_total))
         page_total = TOTAL_MAX;
      else
         page_total = page_total + total_type'(n);
   endfunction

   // Applies one request to the shadow state and returns the reply it earns.
   function automatic reply_type serve_request(input kind_type kind,
                                               input logic [COUNT_W-1:0] count,
                                               input addr_type addr,
                                               input addr_type rs,
                                               input addr_type re);
      reply_type   r;
      logic [63:0] sp;
      logic [63:0] ep;
      logic [63:0] len;
      int          e;
      int          h;
      r.status       = STATUS_OK;
      r.page_address = '0;
      case (kind)
         KIND_ALLOC: begin
            if (count > 1 && !vm_on) begin
               r.status = STATUS_MULTI_PAGE;
            end else if (!list_live) begin
               r.status = STATUS_NO_MEMORY;
            end else begin
               // Only ever one page, taken from the front of the head run.
               h = head;
               r.page_address = addr_type'({run_first[h], {PAGE_SHIFT{1'b0}}});
               if (run_pages[h] > 1) begin
                  run_first[h] = run_first[h] + 1'b1;
                  run_pages[h] = run_pages[h] - 1'b1;
               end else begin
                  if (run_next[h] == h)
                     list_live = 1'b0;
                  else
                     head = run_next[h];
                  retire_entry(h);
               end
               if (page_total != 0)
                  page_total = page_total - 1'b1;
            end
         end
         KIND_FREE: begin
            // Alignment is checked ahead of the kernel end.
            if ((64'(addr) & PAGE_ROUND) != 0) begin
               r.status = STATUS_MISALIGNED;
            end else if (addr < kernel_end) begin
               r.status = STATUS_BELOW_KERN;
            end else if (!entry_available()) begin
               r.status = STATUS_TABLE_FULL;
            end else begin
               e = claim_entry();
               run_first[e] = addr[ADDR_W-1:PAGE_SHIFT];
               run_pages[e] = 1;
               run_next[e]  = list_live ? head : e;
               head         = e;
               list_live    = 1'b1;
               credit_pages(64'h1);
            end
         end
         KIND_RANGE: begin
            // Both ends round up; wide arithmetic keeps the carry out of the top.
            sp = (64'(rs) + PAGE_ROUND) >> PAGE_SHIFT;
            ep = (64'(re) + PAGE_ROUND) >> PAGE_SHIFT;
            if (ep <= sp) begin
               r.status = STATUS_EMPTY_RNG;
            end else if (!entry_available()) begin
               r.status = STATUS_TABLE_FULL;
            end else begin
               len = ep - sp;
               if (len > PAGE_NUMBER_MAX)
                  len = PAGE_NUMBER_MAX;
               e = claim_entry();
               run_first[e] = sp[PN_W-1:0];
               run_pages[e] = len[PN_W-1:0];
               if (!list_live) begin
                  run_next[e] = e;
                  head        = e;
                  list_live   = 1'b1;
               end else begin
                  // Spliced in directly behind the head run.
                  h = head;
                  run_next[e] = (run_next[h] == h) ? e : run_next[h];
                  run_next[h] = e;
               end
               credit_pages(len);
            end
         end
         default: begin
            // An unknown kind leaves everything as it is.
         end
      endcase
      r.free_pages = page_total;
      return r;
   endfunction

   // Compares one result beat with the oldest reply owed.
   task automatic check_reply();
      reply_type want;
      if (awaited_replies.size() == 0) begin
         report_mismatch($sformatf("result beat status %0d with no request owed",
                                   rsp_status));
      end else begin
         want = awaited_replies.pop_front();
         status_seen[want.status]++;
         if (rsp_status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d",
                                      rsp_status, want.status));
         if (rsp_page_address !== want.page_address)
            report_mismatch($sformatf("page address %h, wanted %h",
                                      rsp_page_address, want.page_address));
         if (rsp_free_pages !== want.free_pages)
            report_mismatch($sformatf("free pages %0d, wanted %0d",
                                      rsp_free_pages, want.free_pages));
      end
   endtask

   // Sample every channel at the rising edge, results ahead of new requests.
   always @(posedge clock) begin
      if (reset) begin
         head           = 0;
         spare_top      = 0;
         unused_entries = RUN_ENTRIES;
         list_live      = 1'b0;
         spare_live     = 1'b0;
         page_total     = '0;
         vm_on          = 1'b0;
         kernel_end     = '0;
         runs_held      = 0;
         runs_peak      = 0;
         register_writes = 0;
         closed         = 1'b0;
         failures       = 0;
         foreach (status_seen[i])
            status_seen[i] = 0;
         awaited_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_reply();
         if (csr_valid && csr_ready) begin
            register_writes++;
            case (csr_index)
               CSR_VM_ENABLED: vm_on      = csr_wdata[0];
               CSR_KERNEL_END: kernel_end = csr_wdata[ADDR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            awaited_replies.push_back(serve_request(req_kind, req_page_count,
                                                    req_address, req_range_start,
                                                    req_range_end));
         if (end_of_test && !closed) begin
            closed = 1'b1;
            if (awaited_replies.size() != 0)
               report_mismatch($sformatf("%0d replies never arrived",
                                         awaited_replies.size()));
            $display("Checked %0d replies after %0d register writes: %0d ok, %0d out of memory,",
                     status_seen[STATUS_OK] + status_seen[STATUS_NO_MEMORY]
                     + status_seen[STATUS_MULTI_PAGE] + status_seen[STATUS_MISALIGNED]
                     + status_seen[STATUS_BELOW_KERN] + status_seen[STATUS_EMPTY_RNG]
                     + status_seen[STATUS_TABLE_FULL], register_writes,
                     status_seen[STATUS_OK], status_seen[STATUS_NO_MEMORY]);
            $display(
               "  %0d multi-page, %0d misaligned, %0d too low, %0d empty, %0d full; peak %0d runs.",
                     status_seen[STATUS_MULTI_PAGE], status_seen[STATUS_MISALIGNED],
                     status_seen[STATUS_BELOW_KERN], status_seen[STATUS_EMPTY_RNG],
                     status_seen[STATUS_TABLE_FULL], runs_peak);
         end
      end
      outstanding = awaited_replies.size();
   end

endmodule

/* verif/tb.sv */
// ============================================================================
// Page frame run allocator: testbench top
// Drives directed and random allocate, free and add range requests through
// several register settings, with random idling on both channels, and leaves
// prediction and comparison to the result checker beside the block.
// ============================================================================
`timescale 1ns / 1ps

module tb;
   import pfra_pkg::*;

   localparam int RUN_ENTRIES = 1024;
   localparam int PAGE_SHIFT  = 12;
   localparam int PAGE_SIZE   = 1 << PAGE_SHIFT;
   localparam addr_type PAGE_BYTES  = addr_type'(PAGE_SIZE);
   localparam addr_type OFFSET_MASK = PAGE_BYTES - 1'b1;
   localparam addr_type ADDR_MAX    = '1;
   localparam kind_type KIND_UNKNOWN = 2'd3;

   typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} traffic_mix_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_valid;
   logic                    csr_ready;
   csr_idx_type             csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    req_valid;
   logic                    req_ready;
   kind_type                req_kind;
   logic [COUNT_W-1:0]      req_page_count;
   addr_type                req_address;
   addr_type                req_range_start;
   addr_type                req_range_end;
   logic                    rsp_valid;
   logic                    rsp_ready;
   status_type              rsp_status;
   addr_type                rsp_page_address;
   total_type               rsp_free_pages;
   logic                    end_of_test;
   int                      outstanding;
   int                      failures;

   // Stimulus-side copies of the registers and the burst switches.
   addr_type                kernel_end;
   logic                    req_burst;
   logic                    rsp_burst;

   page_frame_run_allocator #(
      .RUN_ENTRIES (RUN_ENTRIES),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_page_count   (req_page_count),
      .req_address      (req_address),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .rsp_free_pages   (rsp_free_pages)
   );

   pfra_result_check #(
      .RUN_ENTRIES (RUN_ENTRIES),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) result_check (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_page_count   (req_page_count),
      .req_address      (req_address),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .rsp_free_pages   (rsp_free_pages),
      .end_of_test      (end_of_test),
      .outstanding      (outstanding),
      .failures         (failures)
   );

   // 8 ns clock.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic addr_type rand_addr();
      return addr_type'({$urandom, $urandom});
   endfunction

   // Holds the register beat until it is taken; the caller drops valid.
   task automatic write_register(input csr_idx_type idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Stops sending and waits until every owed reply has come back.
   task automatic wait_until_quiet();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic configure(input logic vm, input addr_type kend);
      wait_until_quiet();
      write_register(CSR_VM_ENABLED, CSR_DATA_W'(vm));
      write_register(CSR_KERNEL_END, CSR_DATA_W'(kend));
      csr_valid  <= 1'b0;
      kernel_end  = kend;
   endtask

   // One request beat, preceded by a random idle gap unless in a burst.
   task automatic send_request(input kind_type kind, input logic [COUNT_W-1:0] count,
                               input addr_type addr, input addr_type rs,
                               input addr_type re);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 29) == 0)
         req_burst = !req_burst;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_page_count  <= count;
      req_address     <= addr;
      req_range_start <= rs;
      req_range_end   <= re;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Mostly well-formed requests with random content, weighted by traffic mix.
   task automatic random_request(input traffic_mix_type mix, input int range_pages);
      int                 roll;
      int                 pick;
      int                 alloc_cut;
      int                 free_cut;
      int                 range_cut;
      int                 aligned_cut;
      kind_type           kind;
      logic [COUNT_W-1:0] count;
      addr_type           addr;
      addr_type           rs;
      addr_type           re;
      count = COUNT_W'($urandom);
      addr  = rand_addr();
      rs    = rand_addr();
      re    = rand_addr();
      case (mix)
         MIX_FILL:  begin alloc_cut = 3;  free_cut = 53; range_cut = 98; end
         MIX_DRAIN: begin alloc_cut = 85; free_cut = 91; range_cut = 97; end
         default:   begin alloc_cut = 55; free_cut = 75; range_cut = 95; end
      endcase
      aligned_cut = (mix == MIX_FILL) ? 90 : 70;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      if (roll < alloc_cut) begin
         kind = KIND_ALLOC;
         if (pick < 60)
            count = 1;
         else if (pick < 75)
            count = 0;
      end else if (roll < free_cut) begin
         // Aligned pages, pages either side of the kernel end, or raw noise.
         kind = KIND_FREE;
         if (pick < aligned_cut)
            addr = addr & ~OFFSET_MASK;
         else if (pick < aligned_cut + (100 - aligned_cut) / 2)
            addr = (kernel_end & ~OFFSET_MASK)
                   + addr_type'(PAGE_SIZE * $urandom_range(0, 2)) - PAGE_BYTES;
      end else if (roll < range_cut) begin
         kind = KIND_RANGE;
         if (pick < 50)
            rs = rs & ~OFFSET_MASK;
         if ($urandom_range(0, 99) < 88)
            re = rs + addr_type'($urandom_range(1, range_pages * PAGE_SIZE));
         else
            re = rs - addr_type'($urandom_range(0, 4 * PAGE_SIZE));
      end else begin
         kind = KIND_UNKNOWN;
      end
      send_request(kind, count, addr, rs, re);
   endtask

   task automatic run_phase(input traffic_mix_type mix, input int items,
                            input int range_pages, input logic vm,
                            input addr_type kend);
      configure(vm, kend);
      for (int n = 0; n < items; n++) begin
         // Now and then let the block drain completely before going on.
         if ($urandom_range(0, 149) == 0)
            wait_until_quiet();
         random_request(mix, range_pages);
      end
   endtask

   // Result side: random stalls before each beat, with stretches of none.
   initial begin : result_side
      int stall;
      rsp_ready = 1'b0;
      rsp_burst = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, 14);
         if ($urandom_range(0, 29) == 0)
            rsp_burst = !rsp_burst;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      reset           = 1'b1;
      csr_valid       = 1'b0;
      csr_index       = CSR_VM_ENABLED;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_kind        = KIND_ALLOC;
      req_page_count  = '0;
      req_address     = '0;
      req_range_start = '0;
      req_range_end   = '0;
      end_of_test     = 1'b0;
      kernel_end      = '0;
      req_burst       = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Refusals on an empty list, then a few pages in and out again.
      configure(1'b0, '0);
      send_request(KIND_ALLOC, 1, '0, '0, '0);
      send_request(KIND_ALLOC, 2, '0, '0, '0);
      send_request(KIND_ALLOC, 16'hFFFF, '0, '0, '0);
      send_request(KIND_FREE, 0, 48'h1, '0, '0);
      send_request(KIND_FREE, 0, 48'hFFFF_FFFF_F800, '0, '0);
      send_request(KIND_FREE, 0, '0, '0, '0);
      send_request(KIND_FREE, 0, 48'hFFFF_FFFF_F000, '0, '0);
      send_request(KIND_RANGE, 0, '0, '0, '0);
      send_request(KIND_RANGE, 0, '0, 48'h2000, 48'h1000);
      send_request(KIND_RANGE, 0, '0, 48'h1, 48'h1000);
      send_request(KIND_RANGE, 0, '0, 48'h1, 48'h1001);
      send_request(KIND_UNKNOWN, 16'hFFFF, ADDR_MAX, ADDR_MAX, ADDR_MAX);
      send_request(KIND_ALLOC, 0, '0, '0, '0);
      send_request(KIND_ALLOC, 1, '0, '0, '0);
      send_request(KIND_ALLOC, 1, '0, '0, '0);
      send_request(KIND_ALLOC, 1, '0, '0, '0);

      // Highest kernel end: every free is refused, misalignment first.
      configure(1'b1, ADDR_MAX);
      send_request(KIND_FREE, 0, 48'hFFFF_FFFF_F000, '0, '0);
      send_request(KIND_FREE, 0, 48'h1, '0, '0);
      send_request(KIND_RANGE, 0, '0, 48'h5000, 48'h8000);
      send_request(KIND_ALLOC, 16'hFFFF, '0, '0, '0);
      send_request(KIND_ALLOC, 2, '0, '0, '0);

      // Random phases; the long fill runs the table out of entries.
      run_phase(MIX_BALANCED, 160, 3, 1'b0, '0);
      run_phase(MIX_BALANCED, 120, 3, 1'b1, rand_addr());
      run_phase(MIX_DRAIN, 80, 3, 1'b0, '0);
      run_phase(MIX_FILL, 1350, 8, 1'b1, addr_type'($urandom_range(0, 32'h00FF_FFFF)));
      run_phase(MIX_DRAIN, 200, 3, 1'b1, ADDR_MAX);

      // Whole address space as one run, then the free count saturates.
      configure(1'b1, '0);
      send_request(KIND_RANGE, 0, '0, '0, ADDR_MAX);
      send_request(KIND_RANGE, 0, '0, 48'h0000_0100_0000, 48'h0000_0101_0000);
      send_request(KIND_ALLOC, 16'hFFFF, '0, '0, '0);
      send_request(KIND_ALLOC, 0, '0, '0, '0);
      send_request(KIND_RANGE, 0, '0, 48'hFFFF_FFFF_F001, ADDR_MAX);
      send_request(KIND_FREE, 0, 48'hFFFF_FFFF_F000, '0, '0);
      run_phase(MIX_BALANCED, 50, 3, 1'b1, '0);

      // Drain, let the pipeline settle, then take the verdict.
      wait_until_quiet();
      repeat (16) @(negedge clock);
      end_of_test <= 1'b1;
      @(negedge clock);
      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
